// ----- sv/lrsa_pkg.sv -----
`timescale 1ns / 1ps

package lrsa_pkg;

  localparam logic [11:0] PHASE_SPAN   = 12'd4080;
  localparam logic [11:0] ELAPSED_MAX  = 12'hFFF;
  localparam logic [23:0] AGE_MAX      = 24'hFFFFFF;
  localparam logic [9:0]  TICK_RST     = 10'd16;
  localparam logic [23:0] TIMEOUT_RST  = 24'd300000;
  localparam logic [7:0]  LEVEL_RST    = 8'd5;
  localparam logic [7:0]  SPEED_RST    = 8'd15;
  localparam logic [7:0]  FULL         = 8'hFF;

  localparam logic [7:0] STATUS_DETACHED = 8'd0;
  localparam logic [7:0] STATUS_GREEN    = 8'd1;
  localparam logic [7:0] STATUS_YELLOW   = 8'd2;
  localparam logic [7:0] STATUS_RED      = 8'd3;

  typedef enum logic [1:0] {
    CFG_TICK_PERIOD    = 2'd0,
    CFG_DETACH_TIMEOUT = 2'd1,
    CFG_DEFAULT_LEVEL  = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    F_IDLE,
    F_EVAL
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

  typedef struct packed {
    logic red_on;
    logic green_on;
    logic blue_on;
  } color_t;

  typedef struct packed {
    color_t     color;
    logic [7:0] level;
  } frame_t;

  function automatic logic [7:0] clamp_byte(input logic [7:0] b);
    clamp_byte = (b == 8'd0) ? 8'd1 : b;
  endfunction

  function automatic color_t color_of(input logic [7:0] status);
    color_t c;
    c = '0;
    if (status == STATUS_DETACHED) begin
      c.blue_on = 1'b1;
    end else if (status == STATUS_GREEN) begin
      c.green_on = 1'b1;
    end else if (status == STATUS_YELLOW) begin
      c.red_on   = 1'b1;
      c.green_on = 1'b1;
    end else if (status == STATUS_RED) begin
      c.red_on = 1'b1;
    end else begin
      c = '1;
    end
    color_of = c;
  endfunction

endpackage

// ----- sv/lrsa_queue.sv -----
`timescale 1ns / 1ps

module lrsa_queue #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- sv/lrsa_front.sv -----
`timescale 1ns / 1ps

module lrsa_front #(
  parameter int PIXEL_COUNT    = 16,
  parameter int RUNNER_SPACING = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [23:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           mode,
  input  logic [7:0]                     cmd_status,
  input  logic [7:0]                     cmd_speed,
  input  logic [7:0]                     cmd_brightness,
  input  logic                           q_full,
  output logic                           q_push,
  output lrsa_pkg::frame_t               q_frame,
  output logic [$clog2(PIXEL_COUNT)-1:0] q_start,
  output logic                           busy
);

  localparam int PW  = $clog2(PIXEL_COUNT);
  localparam int PHW = $clog2(RUNNER_SPACING);

  lrsa_pkg::front_state_t state, state_next;

  logic [9:0]     tick_period;
  logic [23:0]    detach_timeout;
  logic [7:0]     default_level;

  logic [PHW-1:0] phase_pos;
  logic [PW-1:0]  pos_mod;
  logic [11:0]    elapsed;
  logic [23:0]    age;
  logic           seen;
  logic [7:0]     cur_status;
  logic [7:0]     cur_speed;
  logic [7:0]     cur_bright;

  logic           fire;
  logic [12:0]    elapsed_sum;
  logic [24:0]    age_sum;
  logic [8:0]     speed_p1;
  logic [20:0]    prod;
  logic           step;
  logic           detach;
  logic           phase_wrap;
  logic [PHW-1:0] phase_pos_next;
  logic [PW-1:0]  pos_mod_next;

  assign fire     = in_valid && in_ready;
  assign in_ready = (state == lrsa_pkg::F_IDLE) && !q_full;
  assign busy     = (state == lrsa_pkg::F_EVAL);

  assign elapsed_sum = {1'b0, elapsed} + {3'b0, tick_period};
  assign age_sum     = {1'b0, age} + {15'b0, tick_period};

  // elapsed > 4080/(speed+1) is the same test as elapsed*(speed+1) > 4080
  assign speed_p1 = {1'b0, cur_speed} + 9'd1;
  assign prod     = 21'(elapsed) * 21'(speed_p1);
  assign step     = prod > 21'(lrsa_pkg::PHASE_SPAN);
  assign detach   = !seen || (age > detach_timeout);

  assign phase_wrap     = (phase_pos == PHW'(RUNNER_SPACING - 1));
  assign phase_pos_next = phase_wrap ? '0 : phase_pos + PHW'(1);
  assign pos_mod_next   = (phase_wrap || pos_mod == PW'(PIXEL_COUNT - 1)) ? '0
                                                                       : pos_mod + PW'(1);

  assign q_push        = busy && step;
  assign q_start       = pos_mod_next;
  assign q_frame.color = lrsa_pkg::color_of(detach ? lrsa_pkg::STATUS_DETACHED : cur_status);
  assign q_frame.level = detach ? default_level : cur_bright;

  always_comb begin
    state_next = state;
    unique case (state)
      lrsa_pkg::F_IDLE: begin
        if (fire && !mode) begin
          state_next = lrsa_pkg::F_EVAL;
        end
      end
      lrsa_pkg::F_EVAL: begin
        state_next = lrsa_pkg::F_IDLE;
      end
      default: begin
        state_next = lrsa_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrsa_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period    <= lrsa_pkg::TICK_RST;
      detach_timeout <= lrsa_pkg::TIMEOUT_RST;
      default_level  <= lrsa_pkg::LEVEL_RST;
    end else if (cfg_write) begin
      unique case (lrsa_pkg::cfg_reg_t'(cfg_index))
        lrsa_pkg::CFG_TICK_PERIOD:    tick_period    <= cfg_data[9:0];
        lrsa_pkg::CFG_DETACH_TIMEOUT: detach_timeout <= cfg_data;
        lrsa_pkg::CFG_DEFAULT_LEVEL:  default_level  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_pos  <= '0;
      pos_mod    <= '0;
      elapsed    <= '0;
      age        <= '0;
      seen       <= 1'b0;
      cur_status <= lrsa_pkg::STATUS_DETACHED;
      cur_speed  <= lrsa_pkg::SPEED_RST;
      cur_bright <= lrsa_pkg::LEVEL_RST;
    end else if (fire) begin
      if (mode) begin
        cur_status <= lrsa_pkg::clamp_byte(cmd_status);
        cur_speed  <= lrsa_pkg::clamp_byte(cmd_speed);
        cur_bright <= lrsa_pkg::clamp_byte(cmd_brightness);
        age        <= '0;
        seen       <= 1'b1;
      end else begin
        elapsed <= elapsed_sum[12] ? lrsa_pkg::ELAPSED_MAX : elapsed_sum[11:0];
        age     <= age_sum[24] ? lrsa_pkg::AGE_MAX : age_sum[23:0];
      end
    end else if (q_push) begin
      phase_pos <= phase_pos_next;
      pos_mod   <= pos_mod_next;
      elapsed   <= '0;
      if (detach) begin
        cur_status <= lrsa_pkg::STATUS_DETACHED;
        cur_bright <= default_level;
      end
    end
  end

endmodule

// ----- sv/lrsa_back.sv -----
`timescale 1ns / 1ps

module lrsa_back #(
  parameter int PIXEL_COUNT    = 16,
  parameter int RUNNER_COUNT   = 2,
  parameter int RUNNER_SPACING = 8,
  parameter int LEAD_OFFSET    = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  output logic                           q_pop,
  input  lrsa_pkg::frame_t               q_frame,
  input  logic [$clog2(PIXEL_COUNT)-1:0] q_start,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [3:0]                     pixel_index,
  output logic [7:0]                     red,
  output logic [7:0]                     green,
  output logic [7:0]                     blue,
  output logic [7:0]                     level,
  output logic                           last
);

  localparam int PW       = $clog2(PIXEL_COUNT);
  localparam int RCW      = (RUNNER_COUNT > 1) ? $clog2(RUNNER_COUNT) : 1;
  localparam int LEAD_MOD = LEAD_OFFSET % PIXEL_COUNT;
  localparam int SP_MOD   = RUNNER_SPACING % PIXEL_COUNT;

  lrsa_pkg::back_state_t state, state_next;

  lrsa_pkg::frame_t frame;
  logic [PW-1:0]    trail;
  logic [RCW-1:0]   runner;
  logic             half;

  logic             emit;
  logic             last_runner;
  logic [PW:0]      lead_sum;
  logic [PW:0]      lead_red;
  logic [PW:0]      trail_sum;
  logic [PW:0]      trail_red;
  logic [PW+3:0]    pos_ext;

  assign emit        = (state == lrsa_pkg::B_RUN) && (!out_valid || out_ready);
  assign last_runner = (runner == RCW'(RUNNER_COUNT - 1));
  assign q_pop       = (state == lrsa_pkg::B_IDLE) && !q_empty;

  assign lead_sum  = {1'b0, trail} + (PW+1)'(LEAD_MOD);
  assign lead_red  = (lead_sum >= (PW+1)'(PIXEL_COUNT)) ? lead_sum - (PW+1)'(PIXEL_COUNT)
                                                         : lead_sum;
  assign trail_sum = {1'b0, trail} + (PW+1)'(SP_MOD);
  assign trail_red = (trail_sum >= (PW+1)'(PIXEL_COUNT)) ? trail_sum - (PW+1)'(PIXEL_COUNT)
                                                          : trail_sum;
  assign pos_ext   = {4'b0, (half ? trail : lead_red[PW-1:0])};

  always_comb begin
    state_next = state;
    unique case (state)
      lrsa_pkg::B_IDLE: begin
        if (!q_empty) begin
          state_next = lrsa_pkg::B_RUN;
        end
      end
      lrsa_pkg::B_RUN: begin
        if (emit && half && last_runner) begin
          state_next = lrsa_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = lrsa_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrsa_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      runner    <= '0;
      half      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        runner <= '0;
        half   <= 1'b0;
      end else if (emit) begin
        half <= ~half;
        if (half) begin
          runner <= runner + RCW'(1);
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      frame <= q_frame;
      trail <= q_start;
    end else if (emit && half) begin
      trail <= trail_red[PW-1:0];
    end
    if (emit) begin
      pixel_index <= pos_ext[3:0];
      level       <= frame.level;
      red         <= (!half && frame.color.red_on)   ? lrsa_pkg::FULL : 8'd0;
      green       <= (!half && frame.color.green_on) ? lrsa_pkg::FULL : 8'd0;
      blue        <= (!half && frame.color.blue_on)  ? lrsa_pkg::FULL : 8'd0;
      last        <= half && last_runner;
    end
  end

endmodule

// ----- sv/led_runner_status_animator_top.sv -----
`timescale 1ns / 1ps

// Status LED runner animator. A command item (mode 1) produces no writes.
// For a tick item (mode 0) the front unit adds the tick period in F_IDLE,
// then in F_EVAL tests for a phase step with a single 12x9 multiply. A
// phase step queues one frame; the back unit then pulls the frame from the
// queue in B_IDLE and emits 2*RUNNER_COUNT pixel writes, one per cycle
// while the output is taken, lead pixel in color then trailing pixel black.
// Up to two frames wait in the queue between front and back; in_ready drops
// while the queue is full, so under steady phase steps the back unit sets
// the sustained rate. The user must write configuration through
// cfg_write/cfg_index/cfg_data only while the block is idle; the block
// itself does not enforce this.
module led_runner_status_animator_top #(
  parameter int PIXEL_COUNT    = 16,
  parameter int RUNNER_COUNT   = 2,
  parameter int RUNNER_SPACING = 8,
  parameter int LEAD_OFFSET    = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  cmd_status,
  input  logic [7:0]  cmd_speed,
  input  logic [7:0]  cmd_brightness,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  pixel_index,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  level,
  output logic        last
);

  localparam int PW = $clog2(PIXEL_COUNT);
  localparam int QW = $bits(lrsa_pkg::frame_t) + PW;

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  lrsa_pkg::frame_t push_frame;
  lrsa_pkg::frame_t pop_frame;
  logic [PW-1:0]    push_start;
  logic [PW-1:0]    pop_start;
  logic [QW-1:0]    q_rdata;
  logic             front_busy;

  assign pop_frame = q_rdata[QW-1:PW];
  assign pop_start = q_rdata[PW-1:0];

  lrsa_front #(
    .PIXEL_COUNT   (PIXEL_COUNT),
    .RUNNER_SPACING(RUNNER_SPACING)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .cmd_status    (cmd_status),
    .cmd_speed     (cmd_speed),
    .cmd_brightness(cmd_brightness),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_frame       (push_frame),
    .q_start       (push_start),
    .busy          (front_busy)
  );

  lrsa_queue #(
    .W(QW)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata({push_frame, push_start}),
    .pop  (q_pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  lrsa_back #(
    .PIXEL_COUNT   (PIXEL_COUNT),
    .RUNNER_COUNT  (RUNNER_COUNT),
    .RUNNER_SPACING(RUNNER_SPACING),
    .LEAD_OFFSET   (LEAD_OFFSET)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_frame    (pop_frame),
    .q_start    (pop_start),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_index(pixel_index),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .level      (level),
    .last       (last)
  );

`ifndef SYNTH
  // a frame is only queued when there is room for it
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("frame queued into a full queue");

  // no new item while a tick is being evaluated
  assert property (@(posedge clk) disable iff (rst) front_busy |-> !in_ready)
    else $error("item accepted during tick evaluation");

  // a command item never starts a frame
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && mode) |=> !q_push)
    else $error("frame queued after a command item");

  // the closing write of a frame is always black
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
    else $error("last write of a frame is not black");
`endif

endmodule

// ----- verif/led_runner_status_animator_top_tb.sv -----
`timescale 1ns / 1ps

module led_runner_status_animator_top_tb;

  localparam int PIXELS       = 16;
  localparam int RUNNERS      = 2;
  localparam int SPACING      = 8;
  localparam int LEAD         = 3;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 500000;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_CMD  = 1'b1;

  typedef struct packed {
    logic [3:0] pix;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] lvl;
    logic       fin;
  } pixel_write_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] status;
    logic [7:0] speed;
    logic [7:0] bright;
    logic       typed;
    logic [2:0] pos;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] lvl;
  } dir_row_t;

  // tick period is 1000 ms during this table; typed rows give the frame they cause
  localparam dir_row_t DIR_ROWS [20] = '{
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 3'd1, 8'h00, 8'h00, lrsa_pkg::FULL, 8'd5},
    '{MODE_CMD,  8'h00, 8'h00, 8'h00, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{MODE_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 3'd2, 8'h00, lrsa_pkg::FULL, 8'h00, 8'd1},
    '{MODE_CMD,  8'hFF, 8'hFF, 8'hFF, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 3'd3, lrsa_pkg::FULL, lrsa_pkg::FULL,
      lrsa_pkg::FULL, 8'hFF},
    '{MODE_CMD,  lrsa_pkg::STATUS_YELLOW, 8'h80, 8'h80, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00,
      8'h00},
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 3'd4, lrsa_pkg::FULL, lrsa_pkg::FULL, 8'h00,
      8'h80},
    '{MODE_CMD,  lrsa_pkg::STATUS_RED, 8'h7F, 8'h7F, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 3'd5, lrsa_pkg::FULL, 8'h00, 8'h00, 8'h7F},
    '{MODE_CMD,  8'h04, 8'h01, 8'h01, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{MODE_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{MODE_TICK, 8'h5A, 8'hA5, 8'h3C, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 3'd6, lrsa_pkg::FULL, lrsa_pkg::FULL,
      lrsa_pkg::FULL, 8'd1},
    '{MODE_CMD,  lrsa_pkg::STATUS_GREEN, 8'hFE, 8'hAA, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00,
      8'h00},
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 3'd7, 8'h00, lrsa_pkg::FULL, 8'h00, 8'hAA},
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 3'd0, 8'h00, lrsa_pkg::FULL, 8'h00, 8'hAA},
    '{MODE_CMD,  8'hAA, 8'h55, 8'h55, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{MODE_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = 1'b0;
  logic [7:0]  cmd_status = '0;
  logic [7:0]  cmd_speed = '0;
  logic [7:0]  cmd_brightness = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  pixel_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  level;
  logic        last;

  led_runner_status_animator_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .cmd_status     (cmd_status),
    .cmd_speed      (cmd_speed),
    .cmd_brightness (cmd_brightness),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pixel_index    (pixel_index),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .level          (level),
    .last           (last)
  );

  // animator mirror
  logic [9:0]  tick_ms;
  logic [23:0] timeout_ms;
  logic [7:0]  idle_level;
  int          anim_pos;
  int          anim_elapsed;
  int          cmd_age;
  bit          cmd_seen;
  logic [7:0]  status_q;
  logic [7:0]  speed_q;
  logic [7:0]  bright_q;

  pixel_write_t pending_writes[$];
  int  failures = 0;
  int  cycles = 0;
  int  burst_left = 0;
  bit  steady = 1'b0;
  bit  hold_ready = 1'b0;
  int  rx_mode = 0;
  int  rx_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) begin
      return 8'h00;
    end else if (sel == 1) begin
      return 8'hFF;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic reset_mirror();
    tick_ms = lrsa_pkg::TICK_RST;
    timeout_ms = lrsa_pkg::TIMEOUT_RST;
    idle_level = lrsa_pkg::LEVEL_RST;
    anim_pos = 0;
    anim_elapsed = 0;
    cmd_age = 0;
    cmd_seen = 1'b0;
    status_q = lrsa_pkg::STATUS_DETACHED;
    speed_q = lrsa_pkg::SPEED_RST;
    bright_q = lrsa_pkg::LEVEL_RST;
  endtask

  task automatic push_frame(input int pos, input logic [7:0] r, g, b, lvl);
    int trail;
    int lead_pix;
    for (int i = 0; i < RUNNERS; i++) begin
      trail = (i * SPACING + pos) % PIXELS;
      lead_pix = (trail + LEAD) % PIXELS;
      pending_writes.push_back('{4'(lead_pix), r, g, b, lvl, 1'b0});
      pending_writes.push_back('{4'(trail), 8'h00, 8'h00, 8'h00, lvl, (i == RUNNERS - 1)});
    end
  endtask

  task automatic model_item(input logic m, input logic [7:0] st, sp, br, input bit quiet);
    int span;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    if (m == MODE_CMD) begin
      status_q = (st == 8'h00) ? 8'h01 : st;
      speed_q = (sp == 8'h00) ? 8'h01 : sp;
      bright_q = (br == 8'h00) ? 8'h01 : br;
      cmd_age = 0;
      cmd_seen = 1'b1;
      return;
    end
    anim_elapsed = anim_elapsed + int'(tick_ms);
    if (anim_elapsed > int'(lrsa_pkg::ELAPSED_MAX)) anim_elapsed = int'(lrsa_pkg::ELAPSED_MAX);
    cmd_age = cmd_age + int'(tick_ms);
    if (cmd_age > int'(lrsa_pkg::AGE_MAX)) cmd_age = int'(lrsa_pkg::AGE_MAX);
    span = int'(lrsa_pkg::PHASE_SPAN) / (int'(speed_q) + 1);
    if (anim_elapsed <= span) return;
    anim_pos = (anim_pos + 1) % SPACING;
    anim_elapsed = 0;
    if (!cmd_seen || cmd_age > int'(timeout_ms)) begin
      bright_q = idle_level;
      status_q = lrsa_pkg::STATUS_DETACHED;
    end
    r = 8'h00;
    g = 8'h00;
    b = 8'h00;
    case (status_q)
      lrsa_pkg::STATUS_DETACHED: b = lrsa_pkg::FULL;
      lrsa_pkg::STATUS_GREEN: g = lrsa_pkg::FULL;
      lrsa_pkg::STATUS_YELLOW: begin
        r = lrsa_pkg::FULL;
        g = lrsa_pkg::FULL;
      end
      lrsa_pkg::STATUS_RED: r = lrsa_pkg::FULL;
      default: begin
        r = lrsa_pkg::FULL;
        g = lrsa_pkg::FULL;
        b = lrsa_pkg::FULL;
      end
    endcase
    if (!quiet) push_frame(anim_pos, r, g, b, bright_q);
  endtask

  task automatic send_item(input logic m, input logic [7:0] st, sp, br, input bit quiet);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!steady && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    mode <= m;
    cmd_status <= st;
    cmd_speed <= sp;
    cmd_brightness <= br;
    do @(posedge clk); while (!in_ready);
    model_item(m, st, sp, br, quiet);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input lrsa_pkg::cfg_reg_t idx, input logic [23:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      lrsa_pkg::CFG_TICK_PERIOD: tick_ms = val[9:0];
      lrsa_pkg::CFG_DETACH_TIMEOUT: timeout_ms = val;
      lrsa_pkg::CFG_DEFAULT_LEVEL: idle_level = val[7:0];
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [23:0] tick, timeout, lvl);
    settle();
    write_reg(lrsa_pkg::CFG_TICK_PERIOD, tick);
    write_reg(lrsa_pkg::CFG_DETACH_TIMEOUT, timeout);
    write_reg(lrsa_pkg::CFG_DEFAULT_LEVEL, lvl);
  endtask

  task automatic random_items(input int count);
    logic m;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 19) == 0) begin
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending_writes.size() != 0);
      end
      m = ($urandom_range(0, 4) == 0) ? MODE_CMD : MODE_TICK;
      send_item(m, rand_byte(), rand_byte(), rand_byte(), 1'b0);
    end
  endtask

  // receiver: checks each write and stalls on a randomly re-picked pattern unless hold_ready is set
  always @(posedge clk) begin
    pixel_write_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        $error("pixel write with none expected: pixel_index %0d", pixel_index);
        failures++;
      end else begin
        want = pending_writes.pop_front();
        if (pixel_index !== want.pix) begin
          $error("pixel_index: expected %0d, got %0d", want.pix, pixel_index);
          failures++;
        end
        if (red !== want.r) begin
          $error("red: expected %0d, got %0d", want.r, red);
          failures++;
        end
        if (green !== want.g) begin
          $error("green: expected %0d, got %0d", want.g, green);
          failures++;
        end
        if (blue !== want.b) begin
          $error("blue: expected %0d, got %0d", want.b, blue);
          failures++;
        end
        if (level !== want.lvl) begin
          $error("level: expected %0d, got %0d", want.lvl, level);
          failures++;
        end
        if (last !== want.fin) begin
          $error("last: expected %0d, got %0d", want.fin, last);
          failures++;
        end
      end
    end
    rx_count++;
    if (rx_count % 48 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_ready) begin
      out_ready <= 1'b1;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (rx_count % 4 == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin
    reset_mirror();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(lrsa_pkg::CFG_TICK_PERIOD, 24'd1000);
    foreach (DIR_ROWS[k]) begin
      send_item(DIR_ROWS[k].mode, DIR_ROWS[k].status, DIR_ROWS[k].speed,
                DIR_ROWS[k].bright, DIR_ROWS[k].typed);
      if (DIR_ROWS[k].typed) begin
        push_frame(DIR_ROWS[k].pos, DIR_ROWS[k].r, DIR_ROWS[k].g, DIR_ROWS[k].b,
                   DIR_ROWS[k].lvl);
      end
    end

    // timeout of 1: every phase step falls back to blue at level zero
    set_regs(24'(lrsa_pkg::TICK_RST), 24'd1, 24'd0);
    random_items(40);
    // slowest ticks, age never detaches, brightest default
    set_regs(24'd1, 24'(lrsa_pkg::AGE_MAX), 24'd255);
    random_items(20);
    // zero tick period: elapsed and age stop growing, so only a new speed can bring a phase step
    set_regs(24'd0, 24'(lrsa_pkg::TIMEOUT_RST), 24'(lrsa_pkg::LEVEL_RST));
    random_items(10);

    // timeout at its top with long ticks and the output always taken
    set_regs(24'd1000, 24'(lrsa_pkg::AGE_MAX), 24'd200);
    steady = 1'b1;
    hold_ready = 1'b1;
    send_item(MODE_CMD, lrsa_pkg::STATUS_RED, 8'h01, 8'h33, 1'b0);
    repeat (6) send_item(MODE_TICK, rand_byte(), rand_byte(), rand_byte(), 1'b0);
    steady = 1'b0;
    hold_ready = 1'b0;

    repeat (2) begin
      set_regs(24'($urandom_range(1, 1000)), 24'($urandom_range(500, 40000)),
               24'($urandom_range(0, 255)));
      random_items(25);
    end

    settle();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
